// ----- src/interval_bounds_alu_defines.svh -----
// Assertion macros for the interval bounds ALU checker.
`ifndef INTERVAL_BOUNDS_ALU_DEFINES_SVH
`define INTERVAL_BOUNDS_ALU_DEFINES_SVH

// same-cycle implication, off during reset
`define IBALU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define IBALU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked during reset too
`define IBALU_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/ibalu_pkg.sv -----
// Shared types, constants and helper functions for the interval bounds ALU.
package ibalu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int GUARD_W    = 16;
  localparam int LANES      = 4;
  localparam int NUM_W      = DATA_WIDTH + FRAC_BITS;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int MUL_W      = PROD_W - FRAC_BITS;
  localparam int CMP_W      = (NUM_W > MUL_W) ? NUM_W : MUL_W;
  localparam logic [GUARD_W-1:0] GUARD_RESET = GUARD_W'(66);

  typedef enum logic [2:0] {
    OP_MUL   = 3'd0,
    OP_DIV   = 3'd1,
    OP_SCALE = 3'd2,
    OP_RDIV  = 3'd3,
    OP_ADD   = 3'd4,
    OP_SUB   = 3'd5
  } op_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] d_mag;
    logic                  neg;
    logic                  is_div;
  } lane_in_t;

  typedef struct packed {
    logic                         vld;
    logic                         ok;
    logic                         addsub;
    logic signed [DATA_WIDTH-1:0] as_lo;
    logic signed [DATA_WIDTH-1:0] as_hi;
    logic                         as_sat;
  } side_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] v;
    logic                         s;
  } sval_t;

  function automatic logic [DATA_WIDTH-1:0] mag(input logic signed [DATA_WIDTH-1:0] x);
    return x[DATA_WIDTH-1] ? -x : x;
  endfunction

  function automatic logic too_small(input logic signed [DATA_WIDTH-1:0] x,
                                     input logic [GUARD_W-1:0] g);
    logic [DATA_WIDTH-1:0] m;
    m = mag(x);
    return (m == '0) || (m < DATA_WIDTH'(g));
  endfunction

  function automatic lane_in_t mk_lane(input logic signed [DATA_WIDTH-1:0] a,
                                       input logic signed [DATA_WIDTH-1:0] b,
                                       input logic is_div);
    lane_in_t l;
    l.a_mag  = mag(a);
    l.d_mag  = mag(b);
    l.neg    = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    l.is_div = is_div;
    return l;
  endfunction

  function automatic sval_t clamp_wide(input logic signed [DATA_WIDTH:0] w);
    sval_t r;
    r.s = w[DATA_WIDTH] != w[DATA_WIDTH-1];
    if (r.s) begin
      r.v = w[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else begin
      r.v = w[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/ibalu_in_if.sv -----
// Input channel: operation, two intervals and a scalar.
interface ibalu_in_if import ibalu_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   op;
  logic signed [DATA_WIDTH-1:0] x_lo;
  logic signed [DATA_WIDTH-1:0] x_hi;
  logic signed [DATA_WIDTH-1:0] y_lo;
  logic signed [DATA_WIDTH-1:0] y_hi;
  logic signed [DATA_WIDTH-1:0] scalar;

  modport source (output valid, op, x_lo, x_hi, y_lo, y_hi, scalar, input ready);
  modport sink   (input valid, op, x_lo, x_hi, y_lo, y_hi, scalar, output ready);
endinterface

// ----- src/ibalu_out_if.sv -----
// Output channel: result interval bounds and flags.
interface ibalu_out_if import ibalu_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_lo;
  logic signed [DATA_WIDTH-1:0] res_hi;
  logic                         valid_res;
  logic                         saturated;

  modport source (output valid, res_lo, res_hi, valid_res, saturated, input ready);
  modport sink   (input valid, res_lo, res_hi, valid_res, saturated, output ready);
endinterface

// ----- src/ibalu_lane.sv -----
// One corner lane: registered multiply or pipelined restoring divide, then saturate.
module ibalu_lane import ibalu_pkg::*; (
  input  logic                         clk,
  input  logic                         en,
  input  lane_in_t                     li,
  output logic signed [DATA_WIDTH-1:0] val,
  output logic                         sat
);

  logic [DATA_WIDTH-1:0] rem   [NUM_W];
  logic [NUM_W-1:0]      quo   [NUM_W];
  logic [NUM_W-1:0]      num   [NUM_W];
  logic [DATA_WIDTH-1:0] dv    [NUM_W];
  logic [MUL_W-1:0]      prod  [NUM_W];
  logic                  neg   [NUM_W];
  logic                  isdiv [NUM_W];

  logic [DATA_WIDTH-1:0] rem_i   [NUM_W];
  logic [NUM_W-1:0]      quo_i   [NUM_W];
  logic [NUM_W-1:0]      num_i   [NUM_W];
  logic [DATA_WIDTH-1:0] dv_i    [NUM_W];
  logic [MUL_W-1:0]      prod_i  [NUM_W];
  logic                  neg_i   [NUM_W];
  logic                  isdiv_i [NUM_W];
  logic [PROD_W-1:0]     prod_full;

  assign prod_full = li.a_mag * li.d_mag;

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [DATA_WIDTH:0] r2;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_i[k]   = '0;
      assign quo_i[k]   = '0;
      assign num_i[k]   = {li.a_mag, {FRAC_BITS{1'b0}}};
      assign dv_i[k]    = li.d_mag;
      assign prod_i[k]  = prod_full[PROD_W-1:FRAC_BITS];
      assign neg_i[k]   = li.neg;
      assign isdiv_i[k] = li.is_div;
    end else begin : g_next
      assign rem_i[k]   = rem[k-1];
      assign quo_i[k]   = quo[k-1];
      assign num_i[k]   = num[k-1];
      assign dv_i[k]    = dv[k-1];
      assign prod_i[k]  = prod[k-1];
      assign neg_i[k]   = neg[k-1];
      assign isdiv_i[k] = isdiv[k-1];
    end

    assign r2 = {rem_i[k], num_i[k][NUM_W-1]};
    assign ge = r2 >= {1'b0, dv_i[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]   <= ge ? DATA_WIDTH'(r2 - {1'b0, dv_i[k]}) : r2[DATA_WIDTH-1:0];
        quo[k]   <= {quo_i[k][NUM_W-2:0], ge};
        num[k]   <= num_i[k] << 1;
        dv[k]    <= dv_i[k];
        prod[k]  <= prod_i[k];
        neg[k]   <= neg_i[k];
        isdiv[k] <= isdiv_i[k];
      end
    end
  end

  logic [CMP_W-1:0] mag_u;
  logic [CMP_W-1:0] lim;
  logic [CMP_W-1:0] mag_c;
  logic             over;

  always_comb begin
    mag_u = isdiv[NUM_W-1] ? CMP_W'(quo[NUM_W-1]) : CMP_W'(prod[NUM_W-1]);
    lim   = (CMP_W'(1) << (DATA_WIDTH-1)) - CMP_W'(!neg[NUM_W-1]);
    over  = mag_u > lim;
    mag_c = over ? lim : mag_u;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val <= neg[NUM_W-1] ? -mag_c[DATA_WIDTH-1:0] : mag_c[DATA_WIDTH-1:0];
      sat <= over;
    end
  end

endmodule

// ----- src/interval_bounds_alu.sv -----
// Top level of the interval bounds ALU: operand prep, four corner lanes, min/max output.
//
//   channel  dir  protocol        payload
//   req      in   valid/ready     op, x_lo, x_hi, y_lo, y_hi, scalar
//   rsp      out  valid/ready     res_lo, res_hi, valid_res, saturated
//   cfg      in   write enable    zero_guard (16 bit)
//
// One beat per cycle while no rsp beat is held; rsp.valid rises after these registers:
// operand register, 48-step restoring divider per lane, lane output, min/max register.
// rst (synchronous) clears all valid bits and loads zero_guard with 66.
// A held rsp beat freezes the whole pipe; req.ready drops with it.
module interval_bounds_alu import ibalu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [GUARD_W-1:0] cfg_wdata,
  ibalu_in_if.sink           req,
  ibalu_out_if.source        rsp
);

  logic [GUARD_W-1:0] zero_guard;
  logic               adv;

  lane_in_t lin_next [LANES];
  side_t    side_next;
  lane_in_t lin      [LANES];
  side_t    side_p;
  side_t    side_d   [NUM_W+1];

  logic signed [DATA_WIDTH-1:0] l_val [LANES];
  logic                         l_sat [LANES];

  logic                         o_vld;
  logic signed [DATA_WIDTH-1:0] o_lo;
  logic signed [DATA_WIDTH-1:0] o_hi;
  logic                         o_ok;
  logic                         o_sat;

  assign adv       = !o_vld || rsp.ready;
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_guard <= GUARD_RESET;
    end else if (cfg_we) begin
      zero_guard <= cfg_wdata;
    end
  end

  always_comb begin
    sval_t a;
    sval_t b;
    a = '0;
    b = '0;
    for (int i = 0; i < LANES; i++) lin_next[i] = '0;
    side_next     = '0;
    side_next.vld = req.valid;
    side_next.ok  = 1'b1;
    case (op_t'(req.op))
      OP_MUL, OP_DIV: begin
        lin_next[0] = mk_lane(req.x_lo, req.y_lo, req.op == OP_DIV);
        lin_next[1] = mk_lane(req.x_lo, req.y_hi, req.op == OP_DIV);
        lin_next[2] = mk_lane(req.x_hi, req.y_lo, req.op == OP_DIV);
        lin_next[3] = mk_lane(req.x_hi, req.y_hi, req.op == OP_DIV);
        if (req.op == OP_DIV) begin
          side_next.ok = !(too_small(req.y_lo, zero_guard) || too_small(req.y_hi, zero_guard));
        end
      end
      OP_SCALE: begin
        lin_next[0] = mk_lane(req.x_lo, req.scalar, 1'b0);
        lin_next[1] = mk_lane(req.x_hi, req.scalar, 1'b0);
        lin_next[2] = mk_lane(req.x_lo, req.scalar, 1'b0);
        lin_next[3] = mk_lane(req.x_hi, req.scalar, 1'b0);
      end
      OP_RDIV: begin
        lin_next[0] = mk_lane(req.scalar, req.x_lo, 1'b1);
        lin_next[1] = mk_lane(req.scalar, req.x_hi, 1'b1);
        lin_next[2] = mk_lane(req.scalar, req.x_lo, 1'b1);
        lin_next[3] = mk_lane(req.scalar, req.x_hi, 1'b1);
        side_next.ok = !(too_small(req.x_lo, zero_guard) || too_small(req.x_hi, zero_guard));
      end
      OP_ADD: begin
        a = clamp_wide((DATA_WIDTH+1)'(req.x_lo) + (DATA_WIDTH+1)'(req.scalar));
        b = clamp_wide((DATA_WIDTH+1)'(req.x_hi) + (DATA_WIDTH+1)'(req.scalar));
        side_next.addsub = 1'b1;
      end
      OP_SUB: begin
        a = clamp_wide((DATA_WIDTH+1)'(req.scalar) - (DATA_WIDTH+1)'(req.x_hi));
        b = clamp_wide((DATA_WIDTH+1)'(req.scalar) - (DATA_WIDTH+1)'(req.x_lo));
        side_next.addsub = 1'b1;
      end
      default: begin
        side_next.ok = 1'b0;
      end
    endcase
    side_next.as_lo  = a.v;
    side_next.as_hi  = b.v;
    side_next.as_sat = a.s | b.s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_p <= '0;
      for (int k = 0; k <= NUM_W; k++) side_d[k] <= '0;
    end else if (adv) begin
      side_p    <= side_next;
      side_d[0] <= side_p;
      for (int k = 1; k <= NUM_W; k++) side_d[k] <= side_d[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) lin[i] <= lin_next[i];
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    ibalu_lane u_lane (
      .clk (clk),
      .en  (adv),
      .li  (lin[i]),
      .val (l_val[i]),
      .sat (l_sat[i])
    );
  end

  logic signed [DATA_WIDTH-1:0] mn01, mn23, mx01, mx23;
  logic signed [DATA_WIDTH-1:0] lo_next, hi_next;
  logic                         sat_next;
  side_t                        st;

  always_comb begin
    st       = side_d[NUM_W];
    mn01     = (l_val[1] < l_val[0]) ? l_val[1] : l_val[0];
    mn23     = (l_val[3] < l_val[2]) ? l_val[3] : l_val[2];
    mx01     = (l_val[1] > l_val[0]) ? l_val[1] : l_val[0];
    mx23     = (l_val[3] > l_val[2]) ? l_val[3] : l_val[2];
    lo_next  = (mn23 < mn01) ? mn23 : mn01;
    hi_next  = (mx23 > mx01) ? mx23 : mx01;
    sat_next = l_sat[0] | l_sat[1] | l_sat[2] | l_sat[3];
    if (!st.ok) begin
      lo_next  = '0;
      hi_next  = '0;
      sat_next = 1'b0;
    end else if (st.addsub) begin
      lo_next  = st.as_lo;
      hi_next  = st.as_hi;
      sat_next = st.as_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (adv) begin
      o_vld <= st.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_lo  <= lo_next;
      o_hi  <= hi_next;
      o_ok  <= st.ok;
      o_sat <= sat_next;
    end
  end

  assign rsp.valid     = o_vld;
  assign rsp.res_lo    = o_lo;
  assign rsp.res_hi    = o_hi;
  assign rsp.valid_res = o_ok;
  assign rsp.saturated = o_sat;

endmodule

// ----- src/ibalu_checker.sv -----
// Port-level checks for the interval bounds ALU, bound to the top level.
`include "interval_bounds_alu_defines.svh"

module ibalu_checker import ibalu_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic signed [DATA_WIDTH-1:0] res_lo,
  input logic signed [DATA_WIDTH-1:0] res_hi,
  input logic                         valid_res,
  input logic                         saturated
);

  // refused beat carries zeros and no saturation
  `IBALU_ASSERT_IMPL(a_refused_zero, rsp_valid && !valid_res, res_lo == '0 && res_hi == '0 && !saturated, "refused result not zeroed")
  // empty output stage never blocks input
  `IBALU_ASSERT_IMPL(a_ready_when_empty, !rsp_valid, req_ready, "input stalled with empty output")
  // held beat stays put
  `IBALU_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(res_lo) && $stable(res_hi) && $stable(valid_res) && $stable(saturated), "held beat changed")
  // nothing leaves right after reset
  `IBALU_ASSERT_ALWAYS(a_reset_empty, rst, !rsp_valid, "output valid after reset")

endmodule

bind interval_bounds_alu ibalu_checker u_ibalu_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .res_lo    (rsp.res_lo),
  .res_hi    (rsp.res_hi),
  .valid_res (rsp.valid_res),
  .saturated (rsp.saturated)
);
